// File: src/smct_pkg.sv
// Shared types, codes and helpers for the sorted multiset count table.
// Used by smct_cell and sorted_multiset_count_table_unit; depends on nothing.
package smct_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam logic [FIELD_WIDTH-1:0] MAX_NUMBER = 16'hFFFE;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_ADD     = 2'd1,
      REQ_SAVE    = 2'd2,
      REQ_COMPARE = 2'd3
   } req_code_type;

   typedef logic signed [1:0] order_type;

   localparam order_type ORD_LESS    = 2'sb11;
   localparam order_type ORD_EQUAL   = 2'sb00;
   localparam order_type ORD_GREATER = 2'sb01;

   typedef struct packed {
      logic ins_en;
      logic bump_en;
      logic save_en;
      logic cmp_en;
      logic shift_en;
   } cell_ctrl_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// File: src/smct_cell.sv
// One cell of the sorted table: a current entry, a reference entry and a lane
// that shifts toward cell zero for readout and compare. Depends on smct_pkg.
module smct_cell
   import smct_pkg::*;
#(
   parameter int KEY_W      = 16,
   parameter int SIZE_W     = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [KEY_W-1:0]       item_key,
   input  logic [SIZE_W-1:0]      cur_size,
   input  logic [SIZE_W-1:0]      ref_size,
   input  logic [KEY_W-1:0]       prev_num,
   input  logic [COUNT_WIDTH-1:0] prev_cnt,
   input  logic                   prev_in_use,
   input  logic                   prev_greater,
   input  logic [KEY_W-1:0]       next_lane_num,
   input  logic [COUNT_WIDTH-1:0] next_lane_cnt,
   input  logic                   next_lane_mark,
   input  order_type              next_lane_ord,
   output logic [KEY_W-1:0]       num,
   output logic [COUNT_WIDTH-1:0] cnt,
   output logic                   in_use,
   output logic                   greater,
   output logic                   match,
   output logic [KEY_W-1:0]       lane_num,
   output logic [COUNT_WIDTH-1:0] lane_cnt,
   output logic                   lane_mark,
   output order_type              lane_ord
);

   logic [KEY_W-1:0]       num_ff, num_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0]       ref_num_ff, ref_num_in;
   logic [COUNT_WIDTH-1:0] ref_cnt_ff, ref_cnt_in;
   logic [KEY_W-1:0]       lane_num_ff, lane_num_in;
   logic [COUNT_WIDTH-1:0] lane_cnt_ff, lane_cnt_in;
   logic                   lane_mark_ff, lane_mark_in;
   order_type              lane_ord_ff, lane_ord_in;

   logic                   in_ref;
   logic                   ins_here;
   logic                   shift_here;
   logic                   same;
   logic [KEY_W-1:0]       a_num;
   logic [KEY_W-1:0]       b_num;
   order_type              local_ord;

   assign in_use  = SIZE_W'(CELL_INDEX) < cur_size;
   assign in_ref  = SIZE_W'(CELL_INDEX) < ref_size;
   assign greater = in_use && (num_ff > item_key);
   assign match   = in_use && (num_ff == item_key);

   assign ins_here   = ctrl.ins_en && prev_in_use && !prev_greater && (!in_use || greater);
   assign shift_here = ctrl.ins_en && prev_greater;

   assign same  = in_use && in_ref && (num_ff == ref_num_ff) && (cnt_ff == ref_cnt_ff);
   assign a_num = in_use ? num_ff : '0;
   assign b_num = in_ref ? ref_num_ff : '0;

   always_comb begin
      if (!in_use && !in_ref) begin
         local_ord = ORD_EQUAL;
      end else if (a_num == b_num) begin
         if (cnt_ff > ref_cnt_ff) begin
            local_ord = ORD_LESS;
         end else if (cnt_ff < ref_cnt_ff) begin
            local_ord = ORD_GREATER;
         end else begin
            local_ord = ORD_EQUAL;
         end
      end else if (a_num < b_num) begin
         local_ord = ORD_LESS;
      end else begin
         local_ord = ORD_GREATER;
      end
   end

   always_comb begin
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      ref_num_in   = ref_num_ff;
      ref_cnt_in   = ref_cnt_ff;
      lane_num_in  = lane_num_ff;
      lane_cnt_in  = lane_cnt_ff;
      lane_mark_in = lane_mark_ff;
      lane_ord_in  = lane_ord_ff;
      if (ins_here) begin
         num_in = item_key;
         cnt_in = COUNT_WIDTH'(1);
      end else if (shift_here) begin
         num_in = prev_num;
         cnt_in = prev_cnt;
      end else if (ctrl.bump_en && match) begin
         cnt_in = sat_inc(cnt_ff);
      end
      if (ctrl.save_en) begin
         ref_num_in   = num_ff;
         ref_cnt_in   = cnt_ff;
         lane_num_in  = num_ff;
         lane_cnt_in  = cnt_ff;
         lane_mark_in = SIZE_W'(CELL_INDEX + 1) == cur_size;
         lane_ord_in  = ORD_EQUAL;
      end else if (ctrl.cmp_en) begin
         lane_mark_in = !same;
         lane_ord_in  = local_ord;
      end else if (ctrl.shift_en) begin
         lane_num_in  = next_lane_num;
         lane_cnt_in  = next_lane_cnt;
         lane_mark_in = next_lane_mark;
         lane_ord_in  = next_lane_ord;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      cnt_ff       <= cnt_in;
      ref_num_ff   <= ref_num_in;
      ref_cnt_ff   <= ref_cnt_in;
      lane_num_ff  <= lane_num_in;
      lane_cnt_ff  <= lane_cnt_in;
      lane_mark_ff <= lane_mark_in;
      lane_ord_ff  <= lane_ord_in;
   end

   assign num       = num_ff;
   assign cnt       = cnt_ff;
   assign lane_num  = lane_num_ff;
   assign lane_cnt  = lane_cnt_ff;
   assign lane_mark = lane_mark_ff;
   assign lane_ord  = lane_ord_ff;

   a_sorted_order: assert property (@(posedge clock) disable iff (reset)
      (in_use && prev_in_use && CELL_INDEX != 0) |-> (prev_num < num_ff))
      else $error("Table entries are not in ascending order.");

endmodule

// File: src/sorted_multiset_count_table_unit.sv
// Top level of the sorted multiset count table: request decode, totals,
// response register and the row of smct_cell instances. Depends on smct_pkg.
//
// Usage: requests enter on req_valid/req_ready with req_type and
// req_item_number; results leave on rsp_valid/rsp_ready from one output
// register. Clear, add and a compare decided by the totals each give one
// response in the cycle after acceptance; a new request is taken every
// cycle as long as the receiver drains the responses.
// A save copies the table into the reference bank in the accept cycle and
// then streams one entry per cycle from cell zero of the shift lane while
// the receiver drains them; an empty table gives one response with no entry.
// A compare with equal totals loads a per-cell verdict into the lane and
// shifts it toward cell zero until the first deciding cell.
// When the receiver stalls, the response register holds its value and the
// lane stops shifting; no request is taken until the register can be freed.
// Reset empties both the current table and the reference bank and drops any
// pending response; entries are never cleared in storage, only the sizes.
module sorted_multiset_count_table_unit
   import smct_pkg::*;
#(
   parameter int TABLE_DEPTH  = 64,
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [FIELD_WIDTH-1:0] req_item_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_WIDTH-1:0] rsp_entry_number,
   output logic [COUNT_WIDTH-1:0] rsp_entry_count,
   output logic                   rsp_entry_valid,
   output logic                   rsp_last,
   output order_type              rsp_order,
   output logic                   rsp_status
);

   localparam int KEY_W  = (NUMBER_WIDTH < FIELD_WIDTH) ? NUMBER_WIDTH : FIELD_WIDTH;
   localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAVE,
      ST_CMP
   } state_type;

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      cur_size_ff, cur_size_in;
   logic [SIZE_W-1:0]      ref_size_ff, ref_size_in;
   logic [COUNT_WIDTH-1:0] cur_total_ff, cur_total_in;
   logic [COUNT_WIDTH-1:0] ref_total_ff, ref_total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_entry_number_ff, rsp_entry_number_in;
   logic [COUNT_WIDTH-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic                   rsp_entry_valid_ff, rsp_entry_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   order_type              rsp_order_ff, rsp_order_in;
   logic                   rsp_status_ff, rsp_status_in;

   cell_ctrl_type          ctrl;
   logic                   out_free;
   logic                   accept;
   logic [KEY_W-1:0]       item_key;
   logic                   item_ok;
   logic                   match_any;
   logic                   table_full;

   logic [KEY_W-1:0]       num_w       [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] cnt_w       [TABLE_DEPTH];
   logic                   in_use_w    [TABLE_DEPTH];
   logic                   greater_w   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] match_vec;
   logic [KEY_W-1:0]       lane_num_w  [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] lane_cnt_w  [TABLE_DEPTH];
   logic                   lane_mark_w [TABLE_DEPTH];
   order_type              lane_ord_w  [TABLE_DEPTH];

   logic [KEY_W-1:0]       prev_num_w     [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] prev_cnt_w     [TABLE_DEPTH];
   logic                   prev_in_use_w  [TABLE_DEPTH];
   logic                   prev_greater_w [TABLE_DEPTH];
   logic [KEY_W-1:0]       next_num_w     [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] next_cnt_w     [TABLE_DEPTH];
   logic                   next_mark_w    [TABLE_DEPTH];
   order_type              next_ord_w     [TABLE_DEPTH];

   assign item_key   = req_item_number[KEY_W-1:0];
   assign item_ok    = (item_key != '0) && (FIELD_WIDTH'(item_key) <= MAX_NUMBER);
   assign match_any  = |match_vec;
   assign table_full = cur_size_ff == SIZE_W'(TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_valid && req_ready;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_num_w[i]     = '0;
         assign prev_cnt_w[i]     = '0;
         assign prev_in_use_w[i]  = 1'b1;
         assign prev_greater_w[i] = 1'b0;
      end else begin : g_body
         assign prev_num_w[i]     = num_w[i-1];
         assign prev_cnt_w[i]     = cnt_w[i-1];
         assign prev_in_use_w[i]  = in_use_w[i-1];
         assign prev_greater_w[i] = greater_w[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_num_w[i]  = '0;
         assign next_cnt_w[i]  = '0;
         assign next_mark_w[i] = 1'b1;
         assign next_ord_w[i]  = ORD_EQUAL;
      end else begin : g_link
         assign next_num_w[i]  = lane_num_w[i+1];
         assign next_cnt_w[i]  = lane_cnt_w[i+1];
         assign next_mark_w[i] = lane_mark_w[i+1];
         assign next_ord_w[i]  = lane_ord_w[i+1];
      end

      smct_cell #(
         .KEY_W      (KEY_W),
         .SIZE_W     (SIZE_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .item_key       (item_key),
         .cur_size       (cur_size_ff),
         .ref_size       (ref_size_ff),
         .prev_num       (prev_num_w[i]),
         .prev_cnt       (prev_cnt_w[i]),
         .prev_in_use    (prev_in_use_w[i]),
         .prev_greater   (prev_greater_w[i]),
         .next_lane_num  (next_num_w[i]),
         .next_lane_cnt  (next_cnt_w[i]),
         .next_lane_mark (next_mark_w[i]),
         .next_lane_ord  (next_ord_w[i]),
         .num            (num_w[i]),
         .cnt            (cnt_w[i]),
         .in_use         (in_use_w[i]),
         .greater        (greater_w[i]),
         .match          (match_vec[i]),
         .lane_num       (lane_num_w[i]),
         .lane_cnt       (lane_cnt_w[i]),
         .lane_mark      (lane_mark_w[i]),
         .lane_ord       (lane_ord_w[i])
      );
   end

   always_comb begin
      state_in            = state_ff;
      cur_size_in         = cur_size_ff;
      ref_size_in         = ref_size_ff;
      cur_total_in        = cur_total_ff;
      ref_total_in        = ref_total_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_entry_number_in = rsp_entry_number_ff;
      rsp_entry_count_in  = rsp_entry_count_ff;
      rsp_entry_valid_in  = rsp_entry_valid_ff;
      rsp_last_in         = rsp_last_ff;
      rsp_order_in        = rsp_order_ff;
      rsp_status_in       = rsp_status_ff;
      ctrl                = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in        = 1'b1;
               rsp_entry_number_in = '0;
               rsp_entry_count_in  = '0;
               rsp_entry_valid_in  = 1'b0;
               rsp_last_in         = 1'b1;
               rsp_order_in        = ORD_EQUAL;
               rsp_status_in       = 1'b0;
               unique case (req_type)
                  REQ_CLEAR: begin
                     cur_size_in  = '0;
                     cur_total_in = '0;
                  end
                  REQ_ADD: begin
                     if (item_ok) begin
                        if (match_any) begin
                           ctrl.bump_en = 1'b1;
                           cur_total_in = sat_inc(cur_total_ff);
                        end else if (table_full) begin
                           rsp_status_in = 1'b1;
                        end else begin
                           ctrl.ins_en  = 1'b1;
                           cur_size_in  = cur_size_ff + 1'b1;
                           cur_total_in = sat_inc(cur_total_ff);
                        end
                     end
                  end
                  REQ_SAVE: begin
                     ctrl.save_en = 1'b1;
                     ref_size_in  = cur_size_ff;
                     ref_total_in = cur_total_ff;
                     if (cur_size_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SAVE;
                     end
                  end
                  REQ_COMPARE: begin
                     if (cur_total_ff < ref_total_ff) begin
                        rsp_order_in = ORD_LESS;
                     end else if (cur_total_ff > ref_total_ff) begin
                        rsp_order_in = ORD_GREATER;
                     end else begin
                        ctrl.cmp_en  = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SAVE: begin
            if (out_free) begin
               ctrl.shift_en       = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_entry_number_in = FIELD_WIDTH'(lane_num_w[0]);
               rsp_entry_count_in  = lane_cnt_w[0];
               rsp_entry_valid_in  = 1'b1;
               rsp_last_in         = lane_mark_w[0];
               rsp_order_in        = ORD_EQUAL;
               rsp_status_in       = 1'b0;
               if (lane_mark_w[0]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CMP: begin
            if (out_free) begin
               if (lane_mark_w[0]) begin
                  rsp_valid_in        = 1'b1;
                  rsp_entry_number_in = '0;
                  rsp_entry_count_in  = '0;
                  rsp_entry_valid_in  = 1'b0;
                  rsp_last_in         = 1'b1;
                  rsp_order_in        = lane_ord_w[0];
                  rsp_status_in       = 1'b0;
                  state_in            = ST_IDLE;
               end else begin
                  ctrl.shift_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_size_ff  <= '0;
         ref_size_ff  <= '0;
         cur_total_ff <= '0;
         ref_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_size_ff  <= cur_size_in;
         ref_size_ff  <= ref_size_in;
         cur_total_ff <= cur_total_in;
         ref_total_ff <= ref_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_entry_number_ff <= rsp_entry_number_in;
      rsp_entry_count_ff  <= rsp_entry_count_in;
      rsp_entry_valid_ff  <= rsp_entry_valid_in;
      rsp_last_ff         <= rsp_last_in;
      rsp_order_ff        <= rsp_order_in;
      rsp_status_ff       <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_number = rsp_entry_number_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_entry_valid  = rsp_entry_valid_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_order        = rsp_order_ff;
   assign rsp_status       = rsp_status_ff;

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      (cur_size_ff <= SIZE_W'(TABLE_DEPTH)) && (ref_size_ff <= SIZE_W'(TABLE_DEPTH)))
      else $error("Table size exceeds the depth.");

   a_total_covers_size: assert property (@(posedge clock) disable iff (reset)
      cur_total_ff >= COUNT_WIDTH'(cur_size_ff))
      else $error("Total count is below the number of entries.");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> table_full)
      else $error("A full status was reported for a table with free cells.");

   a_busy_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> (state_ff != ST_IDLE || $past(rsp_valid_in)))
      else $error("A save or compare ended without loading a response.");

endmodule
